/* rtl/core/assert_macros.svh */
// Assertion macros shared by the row unfilter modules.
// No dependencies; every asserting file includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must never hold at a clock edge outside reset
`define PRU_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: assertion failed");

// when a holds, b holds in the same cycle
`define PRU_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: assertion failed");

// when a holds, b holds in the next cycle
`define PRU_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: assertion failed");

`else

`define PRU_ASSERT_NEVER(label, clk, rst, cond)
`define PRU_ASSERT_IMPLIES(label, clk, rst, a, b)
`define PRU_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

/* rtl/core/pru_pkg.sv */
// Shared constants, types and the Paeth predictor for the PNG row unfilter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pru_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ADDR_W     = $clog2(MAX_ROW_BYTES);
  localparam int HIST_W     = $clog2(MAX_PIXEL_BYTES);
  localparam int RB_W       = 14;
  localparam int BPP_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd1;

  // filter type codes
  localparam logic [7:0] FLT_NONE  = 8'd0;
  localparam logic [7:0] FLT_SUB   = 8'd1;
  localparam logic [7:0] FLT_UP    = 8'd2;
  localparam logic [7:0] FLT_AVG   = 8'd3;
  localparam logic [7:0] FLT_PAETH = 8'd4;

  // one filtered data word on its way from the front end to reconstruction
  typedef struct packed {
    logic [7:0]        data;
    logic [7:0]        filter;
    logic [ADDR_W-1:0] addr;
    logic [HIST_W-1:0] hist_sel;
    logic              use_left;
    logic              first_row;
    logic              last;
  } item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    // p - a = b - c, p - b = a - c, p - c = (b - c) + (a - c)
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

/* rtl/core/png_row_unfilter.sv */
// PNG row unfilter: takes one inflated byte per cycle and returns each
// rebuilt data byte; a filter byte yields no word. A data byte's result
// reaches the output register as follows: the accepting edge loads the
// word register and the registered line store read together, and the edge
// that takes the word rebuilds the byte into the output register. Bytes flow
// back to back; the input stalls only while a rebuilt word waits behind an
// output word that is not taken. The line store needs no clearing pass after
// reset. Depends on pru_pkg, pru_ctrl, pru_line_store, pru_recon and
// assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module png_row_unfilter (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] stream_byte
  input  logic                           s_tuser,   // [0] image_start
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] pixel_byte
  output logic                           m_tlast    // last_in_row
);

  logic [pru_pkg::RB_W-1:0]   row_bytes;
  logic [pru_pkg::BPP_W-1:0]  bytes_per_pixel;
  logic [pru_pkg::RB_W-1:0]   rb_eff;
  logic [pru_pkg::BPP_W-1:0]  bpp_eff;
  logic                       accept;
  logic                       item_valid;
  logic                       item_taken;
  pru_pkg::item_t             item;
  logic                       rd_en;
  logic [pru_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 upper;
  logic [7:0]                 pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= pru_pkg::RB_W'(1);
      bytes_per_pixel <= pru_pkg::BPP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pru_pkg::REG_ROW_BYTES:       row_bytes       <= cfg_data;
        pru_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[pru_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = pru_pkg::RB_W'(1);
    end else if (row_bytes > pru_pkg::RB_W'(pru_pkg::MAX_ROW_BYTES)) begin
      rb_eff = pru_pkg::RB_W'(pru_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = row_bytes;
    end
    if (bytes_per_pixel == '0) begin
      bpp_eff = pru_pkg::BPP_W'(1);
    end else if (bytes_per_pixel > pru_pkg::BPP_W'(pru_pkg::MAX_PIXEL_BYTES)) begin
      bpp_eff = pru_pkg::BPP_W'(pru_pkg::MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
  end

  assign item_taken = item_valid && (!m_tvalid || m_tready);
  assign s_tready   = !item_valid || item_taken;
  assign accept     = s_tvalid && s_tready;

  pru_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (s_tdata),
    .image_start (s_tuser),
    .rb_eff      (rb_eff),
    .bpp_eff     (bpp_eff),
    .item_taken  (item_taken),
    .item_valid  (item_valid),
    .item        (item),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  pru_line_store u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (upper),
    .wr_en   (item_taken),
    .wr_addr (item.addr),
    .wr_data (pixel)
  );

  pru_recon u_recon (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .upper (upper),
    .shift (item_taken),
    .pixel (pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_taken) begin
      m_tdata <= pixel;
      m_tlast <= item.last;
    end
  end

  `PRU_ASSERT_IMPLIES(a_full_stalls_input, clk, rst, item_valid && m_tvalid && !m_tready, !s_tready)

endmodule

/* rtl/core/pru_line_store.sv */
// Line store holding the previous decoded row, one byte per entry.
// Depends on pru_pkg and assert_macros.svh; read data registered.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pru_line_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [pru_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                rd_data,
  input  logic                      wr_en,
  input  logic [pru_pkg::ADDR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data
);

  logic [7:0] mem [pru_pkg::MAX_ROW_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while the consumer stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a filter word always separates two visits to the same column
  `PRU_ASSERT_NEVER(a_no_rw_collision, clk, rst, rd_en && wr_en && (rd_addr == wr_addr))

endmodule

/* rtl/core/pru_ctrl.sv */
// Row front end: filter byte capture, column count and line store read issue.
// Depends on pru_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pru_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 stream_byte,
  input  logic                       image_start,
  input  logic [pru_pkg::RB_W-1:0]   rb_eff,
  input  logic [pru_pkg::BPP_W-1:0]  bpp_eff,
  input  logic                       item_taken,
  output logic                       item_valid,
  output pru_pkg::item_t             item,
  output logic                       rd_en,
  output logic [pru_pkg::ADDR_W-1:0] rd_addr
);

  logic [pru_pkg::ADDR_W-1:0] pos;
  logic [7:0]                 filter;
  logic                       awaiting;
  logic                       first_row;
  logic                       is_filter;
  logic                       is_last;

  assign is_filter = image_start || awaiting;
  assign is_last   = ({1'b0, pos} + pru_pkg::RB_W'(1)) >= rb_eff;
  assign rd_en     = accept && !is_filter;
  assign rd_addr   = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      filter     <= pru_pkg::FLT_NONE;
      awaiting   <= 1'b1;
      first_row  <= 1'b1;
      item_valid <= 1'b0;
    end else begin
      // drop the word once taken, load a new one on every data byte
      item_valid <= (item_valid && !item_taken) || rd_en;
      if (accept) begin
        if (is_filter) begin
          // image start mid-row drops the unfinished row
          filter   <= stream_byte;
          awaiting <= 1'b0;
          pos      <= '0;
          if (image_start) begin
            first_row <= 1'b1;
          end
        end else begin
          if (is_last) begin
            awaiting  <= 1'b1;
            first_row <= 1'b0;
            pos       <= '0;
          end else begin
            pos <= pos + pru_pkg::ADDR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      item.data      <= stream_byte;
      item.filter    <= filter;
      item.addr      <= pos;
      item.hist_sel  <= pru_pkg::HIST_W'(bpp_eff - pru_pkg::BPP_W'(1));
      item.use_left  <= pos >= pru_pkg::ADDR_W'(bpp_eff);
      item.first_row <= first_row;
      item.last      <= is_last;
    end
  end

  `PRU_ASSERT_NEXT(a_last_then_filter, clk, rst, rd_en && is_last, awaiting)
  `PRU_ASSERT_NEXT(a_filter_no_item, clk, rst, accept && is_filter, !item_valid)

endmodule

/* rtl/core/pru_recon.sv */
// Byte reconstruction: left and above-left history and the five predictors.
// Depends on pru_pkg.
`timescale 1ns / 1ps

module pru_recon (
  input  logic           clk,
  input  logic           rst,
  input  pru_pkg::item_t item,
  input  logic [7:0]     upper,
  input  logic           shift,
  output logic [7:0]     pixel
);

  logic [7:0] left_hist [pru_pkg::MAX_PIXEL_BYTES];
  logic [7:0] ulft_hist [pru_pkg::MAX_PIXEL_BYTES];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [7:0] pred;

  assign b      = item.first_row ? 8'd0 : upper;
  assign a      = item.use_left ? left_hist[item.hist_sel] : 8'd0;
  assign c      = item.use_left ? ulft_hist[item.hist_sel] : 8'd0;
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (item.filter)
      pru_pkg::FLT_SUB:   pred = a;
      pru_pkg::FLT_UP:    pred = b;
      pru_pkg::FLT_AVG:   pred = sum_ab[8:1];
      pru_pkg::FLT_PAETH: pred = pru_pkg::paeth_pick(a, b, c);
      default:            pred = 8'd0;
    endcase
  end

  assign pixel = item.data + pred;

  // advance both histories once per delivered data word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
        left_hist[k] <= 8'd0;
        ulft_hist[k] <= 8'd0;
      end
    end else if (shift) begin
      for (int k = pru_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist[k] <= left_hist[k-1];
        ulft_hist[k] <= ulft_hist[k-1];
      end
      left_hist[0] <= pixel;
      ulft_hist[0] <= b;
    end
  end

endmodule

/* bench/png_row_unfilter_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the PNG row unfilter: watches the register, input and output
// channels, rebuilds every scanline byte on its own and compares each word.
// Depends on pru_pkg for widths, register indexes and filter codes.

module png_row_unfilter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] stream_byte
  input  logic                           s_tuser,   // [0] image_start
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,   // [7:0] pixel_byte
  input  logic                           m_tlast,   // last_in_row
  output int                             errors,
  output int                             pending,
  output int                             words_in,
  output int                             words_out
);
  import pru_pkg::*;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } pixel_word_t;

  logic [RB_W-1:0]  row_len;
  logic [BPP_W-1:0] px_size;
  logic [7:0]       above_row [MAX_ROW_BYTES];
  logic [7:0]       left_hist [MAX_PIXEL_BYTES];
  logic [7:0]       upleft_hist [MAX_PIXEL_BYTES];
  int unsigned      col;
  logic [7:0]       kind;
  bit               want_filter;
  bit               first_row;
  pixel_word_t      rebuilt_q [$];
  int               fails = 0;
  int               n_in = 0;
  int               n_out = 0;

  task automatic clear_state();
    int k;
    row_len = RB_W'(1);
    px_size = BPP_W'(1);
    for (k = 0; k < MAX_ROW_BYTES; k++) above_row[k] = 8'h00;
    for (k = 0; k < MAX_PIXEL_BYTES; k++) begin
      left_hist[k] = 8'h00;
      upleft_hist[k] = 8'h00;
    end
    col = 0;
    kind = FLT_NONE;
    want_filter = 1'b1;
    first_row = 1'b1;
    rebuilt_q.delete();
  endtask

  function automatic int paeth_choose(input int a, input int b, input int c);
    int est;
    int da;
    int db;
    int dc;
    est = a + b - c;
    da = (est > a) ? est - a : a - est;
    db = (est > b) ? est - b : b - est;
    dc = (est > c) ? est - c : c - est;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Advance the row state by one stream byte; queue the rebuilt word if any.
  task automatic unfilter_byte(input logic [7:0] x, input logic img_start);
    int unsigned len;
    int unsigned px;
    int unsigned p;
    int          a;
    int          b;
    int          c;
    int          guess;
    int          k;
    logic [7:0]  r;
    bit          at_end;
    len = (row_len == 0) ? 1 : ((row_len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_len);
    px = (px_size == 0) ? 1 : ((px_size > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : px_size);
    if (img_start) begin
      first_row = 1'b1;
      want_filter = 1'b1;
      col = 0;
    end
    if (want_filter) begin
      kind = x;
      want_filter = 1'b0;
      col = 0;
      return;
    end
    p = col;
    b = first_row ? 0 : int'(above_row[p % MAX_ROW_BYTES]);
    if (p >= px) begin
      a = left_hist[px - 1];
      c = upleft_hist[px - 1];
    end else begin
      a = 0;
      c = 0;
    end
    case (kind)
      FLT_SUB:   guess = a;
      FLT_UP:    guess = b;
      FLT_AVG:   guess = (a + b) / 2;
      FLT_PAETH: guess = paeth_choose(a, b, c);
      default:   guess = 0;
    endcase
    r = 8'(int'(x) + guess);
    for (k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k - 1];
      upleft_hist[k] = upleft_hist[k - 1];
    end
    left_hist[0] = r;
    upleft_hist[0] = 8'(b);
    above_row[p % MAX_ROW_BYTES] = r;
    at_end = (p + 1 >= len);
    if (at_end) begin
      want_filter = 1'b1;
      first_row = 1'b0;
      col = 0;
    end else begin
      col = p + 1;
    end
    rebuilt_q.push_back('{pix: r, last: at_end});
  endtask

  task automatic report(input string msg);
    if (fails < 20) $display("MISMATCH word %0d: %s", n_out, msg);
    fails++;
  endtask

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_BYTES:       row_len = cfg_data[RB_W-1:0];
          REG_BYTES_PER_PIXEL: px_size = cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        unfilter_byte(s_tdata, s_tuser);
        n_in++;
      end
      if (m_tvalid && m_tready) begin
        if (rebuilt_q.size() == 0) begin
          report($sformatf("word %02h last %0b with nothing expected", m_tdata, m_tlast));
        end else begin
          want = rebuilt_q.pop_front();
          if (m_tdata !== want.pix)
            report($sformatf("pixel_byte %02h, expected %02h", m_tdata, want.pix));
          if (m_tlast !== want.last)
            report($sformatf("last_in_row %0b, expected %0b", m_tlast, want.last));
        end
        n_out++;
      end
    end
    errors <= fails;
    pending <= rebuilt_q.size();
    words_in <= n_in;
    words_out <= n_out;
  end

endmodule

/* bench/png_row_unfilter_tb.sv */
`timescale 1ns / 1ps
// Top of the PNG row unfilter bench: clock, reset, register writes, byte
// stream and output stalls; the checker does the scoring. Depends on pru_pkg.

module png_row_unfilter_tb;
  import pru_pkg::*;

  localparam int          LIMIT        = 4000000;
  localparam int          CHOKE_CYCLES = 400;
  localparam int          RANDOM_BYTES = 1050;
  localparam logic [7:0]  FLT_ODD      = 8'hFF;   // undefined code, acts as None

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [7:0] stream_byte
  logic                  s_tuser;   // [0] image_start
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // [7:0] pixel_byte
  logic                  m_tlast;   // last_in_row

  int          errors;
  int          pending;
  int          words_in;
  int          words_out;
  int unsigned cycles = 0;
  int          reg_writes = 0;
  int          fed = 0;
  int          phase_no = 0;
  bit          steady = 1'b0;

  always #6 clk = ~clk;

  png_row_unfilter dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  png_row_unfilter_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .errors(errors), .pending(pending), .words_in(words_in), .words_out(words_out)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("png_row_unfilter_tb: errors");
      $finish;
    end
  end

  // mostly short idle runs, a few long ones
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_filter();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(FLT_NONE, FLT_PAETH));
    return 8'($urandom_range(FLT_PAETH + 1, FLT_ODD));
  endfunction

  // output side: random stalls plus one long hold while the input keeps coming
  initial begin : rx_side
    int  hold;
    bit  choked;
    hold = 0;
    choked = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!choked && words_in >= 500) begin
        choked = 1'b1;
        m_tready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end else if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        hold = idle_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] value, input logic img_start);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tuser <= img_start;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every word is out and the pipe has emptied.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input int rb, input logic [CFG_DATA_W-1:0] px_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_BYTES;
    cfg_data <= CFG_DATA_W'(rb);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BYTES_PER_PIXEL;
    cfg_data <= px_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  // One setting: well-formed images and rows with random content, and with
  // noise a rare image restart that cuts the open row short.
  task automatic run_phase(input int rb, input int bpp, input int budget, input bit noisy);
    int                    rb_eff;
    int                    left;
    int                    sent;
    logic [CFG_DATA_W-1:0] px_word;
    settle();
    steady = (phase_no % 3 == 2) || !noisy;
    phase_no++;
    px_word = CFG_DATA_W'($urandom);
    px_word[BPP_W-1:0] = BPP_W'(bpp);
    set_regs(rb, px_word);
    rb_eff = (rb < 1) ? 1 : ((rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb);
    put_byte(pick_filter(), 1'b1);
    left = rb_eff;
    sent = 1;
    while (sent < budget) begin
      if (noisy && $urandom_range(0, 199) == 0) begin
        put_byte(pick_filter(), 1'b1);
        left = rb_eff;
      end else if (left == 0) begin
        put_byte(pick_filter(), 1'b0);
        left = rb_eff;
      end else begin
        put_byte(8'($urandom), 1'b0);
        left--;
      end
      sent++;
    end
    fed += sent;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROW_BYTES;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tuser <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: one-byte rows, one-byte pixels
    put_byte(FLT_NONE, 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(FLT_SUB, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(FLT_UP, 1'b0);
    put_byte(8'h01, 1'b0);
    settle();
    set_regs(3, CFG_DATA_W'(1));
    put_byte(FLT_PAETH, 1'b1);
    put_byte(8'h10, 1'b0);
    put_byte(8'h20, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(FLT_AVG, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h01, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(FLT_ODD, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h7F, 1'b0);
    put_byte(8'hFE, 1'b0);
    // restart the image partway through a row
    put_byte(FLT_SUB, 1'b1);
    put_byte(8'h05, 1'b0);
    put_byte(FLT_UP, 1'b1);
    put_byte(8'hAA, 1'b0);
    // shrink the open row: the next word closes it
    settle();
    set_regs(1, CFG_DATA_W'(1));
    put_byte(8'h55, 1'b0);
    // zero in both registers acts as one
    settle();
    set_regs(0, CFG_DATA_W'(0));
    put_byte(FLT_PAETH, 1'b0);
    put_byte(8'h33, 1'b0);

    run_phase(1, 1, 90, 1'b1);
    run_phase(2, 8, 90, 1'b1);
    run_phase(3, 1, 90, 1'b1);
    run_phase(8, 3, 100, 1'b1);
    run_phase(16, 4, 100, 1'b1);
    run_phase(0, 0, 60, 1'b1);
    run_phase(5, 15, 90, 1'b1);
    run_phase(40, 8, 120, 1'b1);
    while (fed < RANDOM_BYTES)
      run_phase($urandom_range(1, 48), $urandom_range(0, 15), $urandom_range(60, 140), 1'b1);
    // widest row setting through the clamp, first bytes of its row
    run_phase(16383, $urandom_range(1, 8), 40, 1'b0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d stream bytes, %0d rebuilt words, %0d register writes in %0d cycles",
             words_in, words_out, reg_writes, cycles);
    $display("rows of 0 to 16383 bytes and pixel sizes 0 to 15, stalls and one long hold");
    if (errors == 0) begin
      $display("png_row_unfilter_tb: clean");
    end else begin
      $display("png_row_unfilter_tb: errors");
    end
    $finish;
  end

endmodule
